/* rtl/calendar_day_counter_with_dst_top_macros.svh */
// assertion macros for the calendar day counter checker
// no dependencies; included by files that hold concurrent assertions
`ifndef CALENDAR_DAY_COUNTER_WITH_DST_TOP_MACROS_SVH
`define CALENDAR_DAY_COUNTER_WITH_DST_TOP_MACROS_SVH

// clocked assertion, disabled while reset is low
`define CALDST_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("caldst assertion failed");

// clocked assertion that also holds during reset
`define CALDST_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("caldst assertion failed");

`endif

/* rtl/caldst_pkg.sv */
// shared types, codes and calendar functions for the calendar day counter
// no dependencies
`default_nettype none

package caldst_pkg;

  typedef logic [11:0] year_t;
  typedef logic [3:0]  month_t;
  typedef logic [4:0]  day_t;
  typedef logic [2:0]  weekday_t;
  typedef logic [4:0]  hour_t;

  typedef enum logic [1:0] {
    CLASS_STD    = 2'd0,
    CLASS_SPRING = 2'd1,
    CLASS_DST    = 2'd2,
    CLASS_FALL   = 2'd3
  } day_class_e;

  typedef enum logic [1:0] {
    ANS_PST     = 2'd0,
    ANS_PDT     = 2'd1,
    ANS_NEITHER = 2'd2,
    ANS_BOTH    = 2'd3
  } zone_e;

  localparam year_t    RESET_YEAR    = 12'd2007;
  localparam month_t   RESET_MONTH   = 4'd1;
  localparam day_t     RESET_DAY     = 5'd1;
  localparam weekday_t RESET_WEEKDAY = 3'd1;

  localparam month_t   MONTH_FEB = 4'd2;
  localparam month_t   MONTH_MAR = 4'd3;
  localparam month_t   MONTH_APR = 4'd4;
  localparam month_t   MONTH_JUN = 4'd6;
  localparam month_t   MONTH_SEP = 4'd9;
  localparam month_t   MONTH_NOV = 4'd11;
  localparam month_t   MONTH_DEC = 4'd12;
  localparam weekday_t SUNDAY    = 3'd7;

  // multiplicative inverse of 25 mod 2^12 and the divisibility bound
  localparam logic [11:0] INV25     = 12'd3113;
  localparam logic [11:0] DIV25_MAX = 12'd163;

  typedef struct packed {
    year_t      year;
    month_t     month;
    day_t       day;
    weekday_t   weekday;
    logic       season;
    day_class_e today_class;
  } cal_state_t;

  function automatic logic leap_year(input year_t y);
    logic [23:0] prod;
    logic        div25;
    prod  = {12'd0, y} * {12'd0, INV25};
    div25 = (prod[11:0] <= DIV25_MAX);
    return (y[1:0] == 2'd0) && (!div25 || (y[3:0] == 4'd0));
  endfunction

  function automatic day_t month_len(input month_t m, input logic leap);
    day_t len;
    case (m)
      MONTH_FEB: len = leap ? 5'd29 : 5'd28;
      MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

/* rtl/caldst_if.sv */
// valid/ready channel interfaces for the calendar day counter
// depends on caldst_pkg
`default_nettype none

interface caldst_in_if;
  logic                 valid;
  logic                 ready;
  logic                 kind;
  caldst_pkg::hour_t    hour;

  modport source (output valid, output kind, output hour, input ready);
  modport sink (input valid, input kind, input hour, output ready);
endinterface

interface caldst_out_if;
  logic                 valid;
  logic                 ready;
  caldst_pkg::year_t    cur_year;
  caldst_pkg::month_t   cur_month;
  caldst_pkg::day_t     cur_day;
  caldst_pkg::weekday_t cur_weekday;
  logic [1:0]           day_class;
  logic [1:0]           zone_answer;

  modport source (
    output valid, output cur_year, output cur_month, output cur_day,
    output cur_weekday, output day_class, output zone_answer, input ready
  );
  modport sink (
    input valid, input cur_year, input cur_month, input cur_day,
    input cur_weekday, input day_class, input zone_answer, output ready
  );
endinterface

`default_nettype wire

/* rtl/caldst_calc.sv */
// next-day and hour classification logic for one item
// depends on caldst_pkg
`default_nettype none

module caldst_calc (
  input  caldst_pkg::cal_state_t state_i,
  input  logic                   kind_i,
  input  caldst_pkg::hour_t      hour_i,
  output caldst_pkg::cal_state_t state_o,
  output caldst_pkg::zone_e      answer_o
);

  caldst_pkg::cal_state_t adv;
  caldst_pkg::day_t       day_inc;
  caldst_pkg::day_t       len;
  logic [3:0]             wk_sum;
  logic [4:0]             mon_sum;
  logic                   roll;
  logic                   spring;
  logic                   fall;

  always_comb begin
    adv     = state_i;
    day_inc = state_i.day + 5'd1;
    wk_sum  = {1'b0, state_i.weekday} + 4'd1;
    mon_sum = {1'b0, state_i.month} + 5'd1;
    len     = caldst_pkg::month_len(state_i.month, caldst_pkg::leap_year(state_i.year));
    roll    = (day_inc > len) || (day_inc == 5'd0);

    adv.day     = day_inc;
    adv.weekday = (wk_sum > 4'd7) ? 3'd1 : wk_sum[2:0];
    if (roll) begin
      adv.day = 5'd1;
      if (mon_sum > {1'b0, caldst_pkg::MONTH_DEC}) begin
        adv.month = 4'd1;
        adv.year  = state_i.year + 12'd1;
      end else begin
        adv.month = mon_sum[3:0];
      end
    end

    spring = (adv.month == caldst_pkg::MONTH_MAR) && (adv.weekday == caldst_pkg::SUNDAY)
             && (adv.day >= 5'd8) && (adv.day <= 5'd14);
    fall   = (adv.month == caldst_pkg::MONTH_NOV) && (adv.weekday == caldst_pkg::SUNDAY)
             && (adv.day <= 5'd7);

    if (spring) begin
      adv.season      = 1'b1;
      adv.today_class = caldst_pkg::CLASS_SPRING;
    end else if (fall) begin
      adv.season      = 1'b0;
      adv.today_class = caldst_pkg::CLASS_FALL;
    end else begin
      adv.today_class = state_i.season ? caldst_pkg::CLASS_DST : caldst_pkg::CLASS_STD;
    end
  end

  always_comb begin
    state_o  = kind_i ? state_i : adv;
    answer_o = caldst_pkg::ANS_PST;
    if (kind_i) begin
      case (state_i.today_class)
        caldst_pkg::CLASS_SPRING: begin
          if (hour_i < 5'd2) begin
            answer_o = caldst_pkg::ANS_PST;
          end else if (hour_i >= 5'd3) begin
            answer_o = caldst_pkg::ANS_PDT;
          end else begin
            answer_o = caldst_pkg::ANS_NEITHER;
          end
        end
        caldst_pkg::CLASS_DST: answer_o = caldst_pkg::ANS_PDT;
        caldst_pkg::CLASS_FALL: begin
          if (hour_i < 5'd1) begin
            answer_o = caldst_pkg::ANS_PDT;
          end else if (hour_i >= 5'd2) begin
            answer_o = caldst_pkg::ANS_PST;
          end else begin
            answer_o = caldst_pkg::ANS_BOTH;
          end
        end
        default: answer_o = caldst_pkg::ANS_PST;
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/calendar_day_counter_with_dst_top.sv */
// calendar day counter with us pacific daylight classification, top level
// depends on caldst_pkg, caldst_if and caldst_calc
//
// in_ch carries items: kind 0 advances the date by one day, kind 1 asks
// how an hour of the current day maps to pst, pdt, neither or both.
// out_ch returns exactly one item per input item: the date and weekday
// after the item, the class of that day and, for a query, the zone answer.
// an item accepted at an edge shows on out_ch after that edge.
// throughput is one item per cycle while out_ch is ready; the date
// registers and the result register both update at the accepting edge, so
// the next-day logic sits between the state registers and themselves.
// in_ch.ready is high while the result register is empty or being taken,
// so a stalled receiver holds the result and stops input until it drains.
// reset sets the date to 2007-01-01, a monday, in the standard season,
// and empties the result register.

`default_nettype none

module calendar_day_counter_with_dst_top (
  input  logic              clk_i,
  input  logic              rst_ni,
  caldst_in_if.sink         in_ch,
  caldst_out_if.source      out_ch
);

  caldst_pkg::cal_state_t state_q;
  caldst_pkg::cal_state_t state_d;
  caldst_pkg::zone_e      answer;
  caldst_pkg::cal_state_t res_q;
  caldst_pkg::zone_e      res_answer_q;
  logic                   out_valid_q;
  logic                   accept;

  assign in_ch.ready = !out_valid_q || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  caldst_calc u_calc (
    .state_i  (state_q),
    .kind_i   (in_ch.kind),
    .hour_i   (in_ch.hour),
    .state_o  (state_d),
    .answer_o (answer)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.year        <= caldst_pkg::RESET_YEAR;
      state_q.month       <= caldst_pkg::RESET_MONTH;
      state_q.day         <= caldst_pkg::RESET_DAY;
      state_q.weekday     <= caldst_pkg::RESET_WEEKDAY;
      state_q.season      <= 1'b0;
      state_q.today_class <= caldst_pkg::CLASS_STD;
      out_valid_q         <= 1'b0;
    end else begin
      if (accept) begin
        state_q <= state_d;
      end
      out_valid_q <= accept || (out_valid_q && !out_ch.ready);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q        <= state_d;
      res_answer_q <= answer;
    end
  end

  assign out_ch.valid       = out_valid_q;
  assign out_ch.cur_year    = res_q.year;
  assign out_ch.cur_month   = res_q.month;
  assign out_ch.cur_day     = res_q.day;
  assign out_ch.cur_weekday = res_q.weekday;
  assign out_ch.day_class   = res_q.today_class;
  assign out_ch.zone_answer = res_answer_q;

endmodule

`default_nettype wire

/* rtl/caldst_checker.sv */
// port-level checker for the calendar day counter, bound to the top level
// depends on caldst_pkg and calendar_day_counter_with_dst_top_macros.svh
`default_nettype none

`include "calendar_day_counter_with_dst_top_macros.svh"

module caldst_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_ready_i,
  input logic                 in_kind_i,
  input logic                 out_valid_i,
  input logic                 out_ready_i,
  input caldst_pkg::month_t   out_month_i,
  input caldst_pkg::day_t     out_day_i,
  input caldst_pkg::weekday_t out_weekday_i,
  input logic [1:0]           out_class_i,
  input logic [1:0]           out_answer_i
);

  logic in_acc;
  logic spring_out;
  logic date_ok;

  assign in_acc     = in_valid_i && in_ready_i;
  assign spring_out = out_valid_i && (out_class_i == caldst_pkg::CLASS_SPRING);
  assign date_ok    = (out_day_i != 5'd0) && (out_month_i != 4'd0)
                      && (out_month_i <= caldst_pkg::MONTH_DEC) && (out_weekday_i != 3'd0);

  `CALDST_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i |=> out_valid_i)
  `CALDST_ASSERT(a_item_result, clk_i, rst_ni, in_acc |=> out_valid_i)
  `CALDST_ASSERT(a_adv_no_answer, clk_i, rst_ni, in_acc && !in_kind_i |=> out_answer_i == caldst_pkg::ANS_PST)
  `CALDST_ASSERT(a_date_range, clk_i, rst_ni, out_valid_i |-> date_ok)
  `CALDST_ASSERT(a_spring_sunday, clk_i, rst_ni, spring_out |-> out_weekday_i == caldst_pkg::SUNDAY && out_month_i == caldst_pkg::MONTH_MAR)

endmodule

bind calendar_day_counter_with_dst_top caldst_checker u_caldst_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_ch.valid),
  .in_ready_i    (in_ch.ready),
  .in_kind_i     (in_ch.kind),
  .out_valid_i   (out_ch.valid),
  .out_ready_i   (out_ch.ready),
  .out_month_i   (out_ch.cur_month),
  .out_day_i     (out_ch.cur_day),
  .out_weekday_i (out_ch.cur_weekday),
  .out_class_i   (out_ch.day_class),
  .out_answer_i  (out_ch.zone_answer)
);

`default_nettype wire
